/* hdl/rsn_pkg.sv */
// ----------------------------------------------------------------------------
// rsn_pkg
// Shared types and constants of the roulette selector without replacement:
// field widths, item kinds, result status codes and controller/datapath links.
// ----------------------------------------------------------------------------
package rsn_pkg;

	// fixed field widths of the stream and configuration ports
	localparam int KIND_W    = 2;
	localparam int FIT_IN_W  = 16;
	localparam int RAND_W    = 16;
	localparam int PICK_W    = 6;
	localparam int STAT_W    = 2;
	localparam int SEL_W     = 7;
	localparam int S_TDATA_W = FIT_IN_W + RAND_W;
	localparam int M_TDATA_W = PICK_W + STAT_W;

	// item kinds carried on the input tuser
	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_LOAD   = 2'd1,
		KIND_SELECT = 2'd2
	} rsn_kind_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_QUOTA = 2'd2
	} rsn_status_t;

	// commands from controller to datapath
	typedef struct packed {
		logic        clear;      // empty the population
		logic        load;       // append one fitness
		logic        take_sel;   // latch the random fraction
		logic        start_sum;  // begin the summing pass
		logic        start_scan; // begin the picking pass
		logic        mul;        // form r * sum
		logic        emit;       // write the result register
		rsn_status_t emit_status;
	} rsn_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic pass_done; // no pass running and nothing in flight
		logic any;       // at least one member left in the last sum
		logic quota;     // picked count has reached the quota
		logic out_free;  // result register can take a beat this cycle
	} rsn_stat_t;

endpackage

/* hdl/rsn_dpath.sv */
// ----------------------------------------------------------------------------
// rsn_dpath
// Datapath: fitness memory, removed flags, summing and picking passes over the
// population, r * sum product, counters and the result register.
// ----------------------------------------------------------------------------
module rsn_dpath
	import rsn_pkg::*;
#(
	parameter int POP_CAPACITY = 64,
	parameter int FITNESS_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [SEL_W-1:0]     cfg_data,
	input  logic [FIT_IN_W-1:0]  fitness,
	input  logic [RAND_W-1:0]    random_fraction,
	input  rsn_cmd_t             cmd,
	output rsn_stat_t            stat,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast
);

	localparam int IDX_W  = $clog2(POP_CAPACITY);
	localparam int CNT_W  = $clog2(POP_CAPACITY + 1);
	localparam int SUM_W  = FITNESS_BITS + CNT_W;
	localparam int RS_W   = RAND_W + SUM_W;
	localparam int FB_IN  = (FITNESS_BITS < FIT_IN_W) ? FITNESS_BITS : FIT_IN_W;
	localparam logic [CNT_W-1:0] CAP = CNT_W'(POP_CAPACITY);

	logic [FITNESS_BITS-1:0] mem_q [POP_CAPACITY];
	logic [FITNESS_BITS-1:0] rd_data_q;
	logic [POP_CAPACITY-1:0] removed_q;
	logic [CNT_W-1:0]        loaded_q;
	logic [SEL_W-1:0]        picked_q;
	logic [SEL_W-1:0]        select_count_q;
	logic [RAND_W-1:0]       r_q;
	logic [CNT_W-1:0]        ptr_q;
	logic                    run_q;
	logic                    scan_q;
	logic                    issue_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic [SUM_W-1:0]        sum_q;
	logic                    any_q;
	logic [SUM_W-1:0]        cum_q;
	logic                    found_q;
	logic [IDX_W-1:0]        chosen_q;
	logic [RS_W-1:0]         rs_q;
	logic                    m_valid_q;
	logic [PICK_W-1:0]       m_idx_q;
	logic [STAT_W-1:0]       m_stat_q;
	logic                    m_last_q;

	logic                    can_load;
	logic                    live_s1;
	logic [SUM_W-1:0]        cum_next;
	logic                    emit_ok;

	assign can_load = loaded_q < CAP;
	assign live_s1  = issue_s1 && !removed_q[idx_s1];
	assign cum_next = cum_q + SUM_W'(rd_data_q);
	assign emit_ok  = cmd.emit && (cmd.emit_status == STAT_OK);

	// fitness memory, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.load && can_load) begin
			mem_q[loaded_q[IDX_W-1:0]] <= FITNESS_BITS'(fitness[FB_IN-1:0]);
		end
		rd_data_q <= mem_q[ptr_q[IDX_W-1:0]];
	end

	// quota register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_count_q <= '0;
		end else if (cfg_we) begin
			select_count_q <= cfg_data;
		end
	end

	// population counters and removed flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			removed_q <= '0;
			loaded_q  <= '0;
			picked_q  <= '0;
		end else if (cmd.clear) begin
			removed_q <= '0;
			loaded_q  <= '0;
			picked_q  <= '0;
		end else begin
			if (cmd.load && can_load) begin
				removed_q[loaded_q[IDX_W-1:0]] <= 1'b0;
				loaded_q <= loaded_q + CNT_W'(1);
			end
			if (emit_ok) begin
				removed_q[chosen_q] <= 1'b1;
				picked_q <= picked_q + SEL_W'(1);
			end
		end
	end

	// address walk over the loaded members, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			scan_q   <= 1'b0;
			ptr_q    <= '0;
			issue_s1 <= 1'b0;
		end else begin
			issue_s1 <= 1'b0;
			if (cmd.start_sum || cmd.start_scan) begin
				run_q  <= 1'b1;
				scan_q <= cmd.start_scan;
				ptr_q  <= '0;
			end else if (run_q) begin
				if (ptr_q < loaded_q) begin
					issue_s1 <= 1'b1;
					ptr_q    <= ptr_q + CNT_W'(1);
				end else begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= ptr_q[IDX_W-1:0];
	end

	// random fraction and r * sum product
	always_ff @(posedge clk) begin
		if (cmd.take_sel) begin
			r_q <= random_fraction;
		end
		if (cmd.mul) begin
			rs_q <= RS_W'(RS_W'(r_q) * RS_W'(sum_q));
		end
	end

	// sum of live members, then running sum and first qualifying member
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			any_q    <= 1'b0;
			cum_q    <= '0;
			found_q  <= 1'b0;
			chosen_q <= '0;
		end else if (cmd.start_sum) begin
			sum_q <= '0;
			any_q <= 1'b0;
		end else if (cmd.start_scan) begin
			cum_q   <= '0;
			found_q <= 1'b0;
		end else if (live_s1) begin
			if (!scan_q) begin
				sum_q <= sum_q + SUM_W'(rd_data_q);
				any_q <= 1'b1;
			end else if (!found_q) begin
				chosen_q <= idx_s1;
				cum_q    <= cum_next;
				if (rs_q < {cum_next, RAND_W'(0)}) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_stat_q <= cmd.emit_status;
			if (emit_ok) begin
				m_idx_q  <= PICK_W'(chosen_q);
				m_last_q <= (SEL_W'(picked_q + SEL_W'(1)) == select_count_q);
			end else begin
				m_idx_q  <= '0;
				m_last_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_stat_q, m_idx_q};
	assign m_tlast  = m_last_q;

	// status to controller
	assign stat.pass_done = !run_q && !issue_s1;
	assign stat.any       = any_q;
	assign stat.quota     = picked_q >= select_count_q;
	assign stat.out_free  = !m_valid_q || m_tready;

	// a result is only written when the register can take it
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_valid_q || m_tready))
		else $error("result written over a waiting beat");

	// a successful pick names a loaded member that is still in the population
	a_pick_live: assert property (@(posedge clk) disable iff (!arst_n)
		emit_ok |-> (CNT_W'(chosen_q) < loaded_q) && !removed_q[chosen_q])
		else $error("picked member not loaded or already removed");

	// every fetched entry lies below the fill count
	a_fetch_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue_s1 |-> (CNT_W'(idx_s1) < loaded_q))
		else $error("pass fetched an entry past the fill count");

endmodule

/* hdl/rsn_ctrl.sv */
// ----------------------------------------------------------------------------
// rsn_ctrl
// Controller: takes input beats, runs the summing and picking passes of a
// select and hands the result to the datapath's result register.
// ----------------------------------------------------------------------------
module rsn_ctrl
	import rsn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [KIND_W-1:0] kind,
	input  rsn_stat_t         stat,
	output rsn_cmd_t          cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SUM  = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_SCAN = 5'b01000,
		ST_HOLD = 5'b10000
	} state_t;

	state_t      state_q;
	state_t      state_d;
	rsn_status_t pend_q;
	rsn_status_t pend_d;

	assign s_tready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		pend_d  = pend_q;
		cmd     = '0;
		cmd.emit_status = pend_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					unique case (kind)
						KIND_CLEAR: cmd.clear = 1'b1;
						KIND_LOAD:  cmd.load  = 1'b1;
						KIND_SELECT: begin
							if (stat.quota) begin
								pend_d  = STAT_QUOTA;
								state_d = ST_HOLD;
							end else begin
								cmd.take_sel  = 1'b1;
								cmd.start_sum = 1'b1;
								state_d       = ST_SUM;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SUM: begin
				if (stat.pass_done) begin
					if (stat.any) begin
						state_d = ST_MUL;
					end else begin
						pend_d  = STAT_EMPTY;
						state_d = ST_HOLD;
					end
				end
			end
			ST_MUL: begin
				cmd.mul        = 1'b1;
				cmd.start_scan = 1'b1;
				state_d        = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.pass_done) begin
					pend_d  = STAT_OK;
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= STAT_OK;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

	// the product is formed exactly once, right before the picking pass
	a_mul_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> (state_q == ST_SCAN))
		else $error("multiply step not followed by picking pass");

	// a finished picking pass always reports a successful pick
	a_scan_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && stat.pass_done |=> (state_q == ST_HOLD) && (pend_q == STAT_OK))
		else $error("picking pass ended without an ok result");

	// after a result beat is written the block is ready again
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> s_tready)
		else $error("not ready after writing a result");

endmodule

/* hdl/roulette_select_no_replace_core.sv */
// ----------------------------------------------------------------------------
// roulette_select_no_replace_core
// Fitness-proportionate selection without replacement over a loaded
// population: clear, load and select beats in, one result beat per select.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tuser: kind; tdata: fitness, random_fraction
//  m_*       out  m_tvalid/m_tready  tdata: picked_index, status; tlast: last
//  cfg_*     in   cfg_we             cfg_data: select_count
//
//  clear and load beats run no pass
//  a select runs one summing pass and one picking
//  pass over the fitness memory, one entry per cycle through its read port
//  a refused select (quota reached) answers without a summing or picking pass
//  reset clears the removed flags and counters at once, no clearing pass
//  the result register lets a new beat in while a result waits on m_tready
// ----------------------------------------------------------------------------
module roulette_select_no_replace_core
	import rsn_pkg::*;
#(
	parameter int POP_CAPACITY = 64,
	parameter int FITNESS_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // fitness, random_fraction
	input  logic [KIND_W-1:0]    s_tuser,  // kind
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // picked_index, status
	output logic                 m_tlast,
	input  logic                 cfg_we,
	input  logic [SEL_W-1:0]     cfg_data
);

	rsn_cmd_t  cmd;
	rsn_stat_t stat;

	// sequencing of passes
	rsn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.kind     (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	// memory, accumulators and result register
	rsn_dpath #(
		.POP_CAPACITY (POP_CAPACITY),
		.FITNESS_BITS (FITNESS_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_data        (cfg_data),
		.fitness         (s_tdata[FIT_IN_W-1:0]),
		.random_fraction (s_tdata[S_TDATA_W-1:FIT_IN_W]),
		.cmd             (cmd),
		.stat            (stat),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast)
	);

endmodule

/* bench/roulette_select_no_replace_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// roulette_select_no_replace_core_tb
// Self-checking bench for the roulette selector without replacement. A short
// table of directed beats covers the refused, empty and zero-sum selects and
// the field extremes. Random clear/load/select runs follow under several
// quota settings. Every select beat is predicted in the bench and each
// result beat is compared with the oldest prediction. The sender runs in
// bursts and the receiver stalls in shifting patterns, with one long hold-off.
// ----------------------------------------------------------------------------
module roulette_select_no_replace_core_tb;
	import rsn_pkg::*;

	localparam int POP_CAP       = 64;
	localparam int SETTLE_CYCLES = 256;
	localparam int ITEM_GOAL     = 1250;
	localparam int HOLD_AFTER    = 400;     // input beats before the long hold-off
	localparam int HOLD_CYCLES   = 1500;
	localparam int LIMIT_CYCLES  = 1500000;
	localparam int EXP_DEPTH     = 16;      // far above the results that can be pending

	// kind code that the block ignores
	localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

	typedef struct packed {
		logic [PICK_W-1:0] idx;
		rsn_status_t       status;
		logic              last;
	} pick_t;

	localparam pick_t NO_PICK = '{6'd0, STAT_OK, 1'b0};

	typedef struct packed {
		logic [SEL_W-1:0]    quota;
		logic [KIND_W-1:0]   kind;
		logic [FIT_IN_W-1:0] fit;
		logic [RAND_W-1:0]   rnd;
		logic                typed;
		pick_t               want;
	} dir_row_t;

	// directed beats; a row with typed set carries its own result
	localparam int DIR_ROWS = 25;
	localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
		'{7'd0,  KIND_SELECT,  16'h0000, 16'h0000, 1'b1, '{6'd0, STAT_QUOTA, 1'b0}},
		'{7'd0,  KIND_LOAD,    16'hFFFF, 16'h0000, 1'b0, NO_PICK},
		'{7'd0,  KIND_IGNORED, 16'hFFFF, 16'hFFFF, 1'b0, NO_PICK},
		'{7'd0,  KIND_SELECT,  16'h0000, 16'hFFFF, 1'b1, '{6'd0, STAT_QUOTA, 1'b0}},
		'{7'd64, KIND_SELECT,  16'h0000, 16'h1234, 1'b0, NO_PICK},
		'{7'd64, KIND_SELECT,  16'h0000, 16'h0000, 1'b1, '{6'd0, STAT_EMPTY, 1'b0}},
		'{7'd64, KIND_CLEAR,   16'hFFFF, 16'hFFFF, 1'b0, NO_PICK},
		'{7'd64, KIND_SELECT,  16'hFFFF, 16'hFFFF, 1'b1, '{6'd0, STAT_EMPTY, 1'b0}},
		'{7'd64, KIND_LOAD,    16'h0000, 16'h0000, 1'b0, NO_PICK},
		'{7'd64, KIND_LOAD,    16'h0000, 16'hFFFF, 1'b0, NO_PICK},
		'{7'd64, KIND_SELECT,  16'h0000, 16'h0000, 1'b0, NO_PICK},
		'{7'd64, KIND_SELECT,  16'h0000, 16'hFFFF, 1'b0, NO_PICK},
		'{7'd64, KIND_CLEAR,   16'h0000, 16'h0000, 1'b0, NO_PICK},
		'{7'd64, KIND_LOAD,    16'hFFFF, 16'h0000, 1'b0, NO_PICK},
		'{7'd64, KIND_LOAD,    16'h0001, 16'h0000, 1'b0, NO_PICK},
		'{7'd64, KIND_LOAD,    16'hFFFF, 16'h0000, 1'b0, NO_PICK},
		'{7'd64, KIND_SELECT,  16'h0000, 16'h0000, 1'b0, NO_PICK},
		'{7'd64, KIND_SELECT,  16'h0000, 16'hFFFF, 1'b0, NO_PICK},
		'{7'd64, KIND_SELECT,  16'h0000, 16'h8000, 1'b0, NO_PICK},
		'{7'd1,  KIND_CLEAR,   16'h0000, 16'h0000, 1'b0, NO_PICK},
		'{7'd1,  KIND_LOAD,    16'h0005, 16'h0000, 1'b0, NO_PICK},
		'{7'd1,  KIND_LOAD,    16'h0007, 16'h0000, 1'b0, NO_PICK},
		'{7'd1,  KIND_SELECT,  16'h0000, 16'h8000, 1'b0, NO_PICK},
		'{7'd1,  KIND_SELECT,  16'h0000, 16'h4000, 1'b1, '{6'd0, STAT_QUOTA, 1'b0}},
		'{7'd1,  KIND_IGNORED, 16'h0000, 16'h0000, 1'b0, NO_PICK}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // fitness, random_fraction
	logic [KIND_W-1:0]    s_tuser;   // kind
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // picked_index, status
	logic                 m_tlast;
	logic                 cfg_we;
	logic [SEL_W-1:0]     cfg_data;

	// typed result that travels beside the beat on offer
	logic  row_typed;
	pick_t row_want;

	// predicted population
	logic [FIT_IN_W-1:0] pop_fit [POP_CAP];
	bit                  pop_gone [POP_CAP];
	int                  pop_loaded;
	int                  pop_picked;
	int                  quota_val;

	// ring of predicted results, oldest at the read count
	pick_t exp_ring [EXP_DEPTH];
	int    exp_wr;
	int    exp_rd;
	int    errors;
	int    items_sent;
	int    beats_in;
	int    cycles;
	int    burst_left;
	int    calm_left;
	int    rx_mode;
	int    rx_left;
	int    hold_left;
	bit    hold_done;

	roulette_select_no_replace_core #(
		.POP_CAPACITY(POP_CAP),
		.FITNESS_BITS(16)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// apply one accepted beat to the predicted population; 1 when a result is due
	function automatic bit pick_predict(input logic [KIND_W-1:0] kind,
			input logic [FIT_IN_W-1:0] fit, input logic [RAND_W-1:0] rnd,
			output pick_t res);
		logic [63:0] total;
		logic [63:0] run;
		int          chosen;
		bit          any;
		res    = NO_PICK;
		total  = '0;
		run    = '0;
		chosen = 0;
		any    = 1'b0;
		case (kind)
			KIND_CLEAR: begin
				foreach (pop_gone[i]) pop_gone[i] = 1'b0;
				pop_loaded = 0;
				pop_picked = 0;
				return 1'b0;
			end
			KIND_LOAD: begin
				if (pop_loaded < POP_CAP) begin
					pop_fit[pop_loaded]  = fit;
					pop_gone[pop_loaded] = 1'b0;
					pop_loaded++;
				end
				return 1'b0;
			end
			KIND_SELECT: begin
				if (pop_picked >= quota_val) begin
					res.status = STAT_QUOTA;
					return 1'b1;
				end
				for (int i = 0; i < pop_loaded; i++) begin
					if (!pop_gone[i]) begin
						total += pop_fit[i];
						any = 1'b1;
					end
				end
				if (!any) begin
					res.status = STAT_EMPTY;
					return 1'b1;
				end
				// first member whose running sum clears r*sum, else last remaining
				for (int i = 0; i < pop_loaded; i++) begin
					if (pop_gone[i])
						continue;
					chosen = i;
					run += pop_fit[i];
					if (64'(rnd) * total < (run << 16))
						break;
				end
				pop_gone[chosen] = 1'b1;
				pop_picked++;
				res.idx  = chosen[PICK_W-1:0];
				res.last = (pop_picked == quota_val);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [FIT_IN_W-1:0] rand_fit();
		case ($urandom_range(0, 7))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'($urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [RAND_W-1:0] rand_frac();
		case ($urandom_range(0, 9))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// offer one beat in the current burst and wait for it to be taken
	task automatic offer(input logic [KIND_W-1:0] kind, input logic [FIT_IN_W-1:0] fit,
			input logic [RAND_W-1:0] rnd, input logic typed, input pick_t want);
		int gap;
		if (burst_left == 0) begin
			gap = (calm_left > 0) ? 0 : $urandom_range(1, 30);
			if (calm_left == 0 && $urandom_range(0, 7) == 0)
				calm_left = $urandom_range(20, 120);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		if (calm_left > 0)
			calm_left--;
		s_tvalid  <= 1'b1;
		s_tuser   <= kind;
		s_tdata   <= {rnd, fit};
		row_typed <= typed;
		row_want  <= want;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (kind != KIND_IGNORED)
			items_sent++;
	endtask

	// let every result out and the last clear or load finish
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_quota(input logic [SEL_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_data  <= val;
		quota_val = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// one quota setting followed by random clear/load/select runs
	task automatic random_phase();
		int               target;
		int               n;
		int               k;
		logic [SEL_W-1:0] q;
		case ($urandom_range(0, 9))
			0:       q = 7'd0;
			1:       q = 7'd64;
			2:       q = 7'd1;
			default: q = 7'($urandom_range(0, 64));
		endcase
		settle();
		write_quota(q);
		target = items_sent + $urandom_range(20, 80);
		while (items_sent < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: begin
					// well-formed run: clear, loads, then selects
					if ($urandom_range(0, 4) != 0)
						offer(KIND_CLEAR, 16'($urandom), 16'($urandom), 1'b0, NO_PICK);
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 70)
						: $urandom_range(1, 12);
					for (int i = 0; i < n; i++)
						offer(KIND_LOAD, rand_fit(), 16'($urandom), 1'b0, NO_PICK);
					k = $urandom_range(1, n + 2);
					for (int i = 0; i < k; i++) begin
						if ($urandom_range(0, 9) == 0)
							offer(KIND_IGNORED, 16'($urandom), 16'($urandom), 1'b0, NO_PICK);
						offer(KIND_SELECT, 16'($urandom), rand_frac(), 1'b0, NO_PICK);
					end
				end
				7: begin
					// noise of any kind
					repeat ($urandom_range(1, 6))
						offer(2'($urandom), 16'($urandom), 16'($urandom), 1'b0, NO_PICK);
				end
				8: begin
					repeat ($urandom_range(1, 4))
						offer(KIND_SELECT, 16'($urandom), rand_frac(), 1'b0, NO_PICK);
				end
				default: begin
					offer(KIND_CLEAR, 16'($urandom), 16'($urandom), 1'b0, NO_PICK);
					offer(KIND_SELECT, 16'($urandom), rand_frac(), 1'b0, NO_PICK);
				end
			endcase
		end
	endtask

	// predict on every input beat, check every result beat
	always @(posedge clk) begin : scoreboard
		pick_t pred;
		pick_t got;
		pick_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				if (s_tuser != KIND_IGNORED)
					beats_in++;
				if (pick_predict(s_tuser, s_tdata[FIT_IN_W-1:0],
						s_tdata[S_TDATA_W-1:FIT_IN_W], pred)) begin
					exp_ring[exp_wr % EXP_DEPTH] = row_typed ? row_want : pred;
					exp_wr++;
				end
			end
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[PICK_W-1:0], rsn_status_t'(m_tdata[M_TDATA_W-1:PICK_W]),
					m_tlast};
				if (exp_wr == exp_rd) begin
					errors++;
					$display("%0t unexpected result beat: index %0d status %0d last %0d",
						$time, got.idx, got.status, got.last);
				end else begin
					want = exp_ring[exp_rd % EXP_DEPTH];
					exp_rd++;
					if (got !== want) begin
						errors++;
						$display("%0t index/status/last expected %0d/%0d/%0d got %0d/%0d/%0d",
							$time, want.idx, want.status, want.last,
							got.idx, got.status, got.last);
					end
				end
			end
		end
	end

	// receiver: shifting stall patterns and one long hold-off
	always @(posedge clk) begin
		if (!hold_done && beats_in >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(16, 256);
			end
			rx_left--;
			case (rx_mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= 1'($urandom_range(0, 1));
				2:       m_tready <= ($urandom_range(0, 4) == 0);
				default: m_tready <= ~m_tready;
			endcase
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		errors     = 0;
		items_sent = 0;
		beats_in   = 0;
		cycles     = 0;
		burst_left = 0;
		calm_left  = 0;
		rx_mode    = 0;
		rx_left    = 0;
		hold_left  = 0;
		hold_done  = 1'b0;
		quota_val  = 0;
		pop_loaded = 0;
		pop_picked = 0;
		exp_wr     = 0;
		exp_rd     = 0;
		foreach (pop_gone[i]) pop_gone[i] = 1'b0;
		foreach (pop_fit[i]) pop_fit[i] = '0;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= KIND_CLEAR;
		m_tready  <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_data  <= '0;
		row_typed <= 1'b0;
		row_want  <= NO_PICK;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, quota rewritten whenever its column changes
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == 0 || DIR_TABLE[i].quota != DIR_TABLE[i-1].quota) begin
				settle();
				write_quota(DIR_TABLE[i].quota);
			end
			offer(DIR_TABLE[i].kind, DIR_TABLE[i].fit, DIR_TABLE[i].rnd,
				DIR_TABLE[i].typed, DIR_TABLE[i].want);
		end

		items_sent = 0;
		while (items_sent < ITEM_GOAL)
			random_phase();

		settle();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
